// ===== rtl/srl_pkg.sv =====
// shared types and constants for the sorted rank lookup block
// no dependencies; imported by every module of the block
package srl_pkg;

    localparam int CAPACITY = 1024;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 11;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             rejected;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wdata;
    } mem_req_t;

    typedef struct packed {
        logic             res_valid;
        logic [CNT_W-1:0] count;
    } eng_status_t;

endpackage

// ===== rtl/srl_mem.sv =====
// single-port value store with a registered read port
// depends on srl_pkg
module srl_mem (
    input  logic              clk,
    input  srl_pkg::mem_req_t req,
    output logic [31:0]       rdata
);
    import srl_pkg::*;

    logic [31:0] mem [CAPACITY];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/srl_engine.sv =====
// command sequencer: clear, append and the query scan over the value store
// depends on srl_pkg; drives srl_mem through a request struct
module srl_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  srl_pkg::in_item_t    in_data,
    output srl_pkg::mem_req_t    mem_req,
    input  logic [31:0]          mem_rdata,
    input  logic                 res_take,
    output srl_pkg::out_item_t   res_data,
    output srl_pkg::eng_status_t status
);
    import srl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   smaller_reg, smaller_next;
    logic               hit_reg, hit_next;
    logic               rd_pending_reg, rd_pending_next;
    logic signed [31:0] key_reg, key_next;
    logic               res_valid_reg, res_valid_next;
    out_item_t          res_reg, res_next;
    logic               accept;
    logic signed [31:0] elem;

    assign in_stall = (state_reg != ST_IDLE) || res_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign elem     = $signed(mem_rdata);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        smaller_next    = smaller_reg;
        hit_next        = hit_reg;
        rd_pending_next = rd_pending_reg;
        key_next        = key_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        mem_req         = '0;
        mem_req.addr    = addr_reg[ADDR_W-1:0];
        mem_req.wdata   = in_data.value;

        if (res_valid_reg && res_take)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next       = '0;
                    res_valid_next = 1'b1;
                    unique case (in_data.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                mem_req.en   = 1'b1;
                                mem_req.we   = 1'b1;
                                mem_req.addr = count_reg[ADDR_W-1:0];
                                count_next   = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_next.rejected = 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            // empty set answers not found at once
                            if (count_reg != '0)
                            begin
                                mem_req.en      = 1'b1;
                                mem_req.addr    = '0;
                                addr_next       = CNT_W'(1);
                                rd_pending_next = 1'b1;
                                key_next        = in_data.value;
                                smaller_next    = '0;
                                hit_next        = 1'b0;
                                res_valid_next  = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_pending_next = 1'b0;
                if (addr_reg < count_reg)
                begin
                    mem_req.en      = 1'b1;
                    rd_pending_next = 1'b1;
                    addr_next       = addr_reg + CNT_W'(1);
                end
                if (rd_pending_reg)
                begin
                    if (elem == key_reg)
                    begin
                        hit_next = 1'b1;
                    end
                    else if (elem < key_reg)
                    begin
                        smaller_next = smaller_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    // last read data compared in the previous cycle
                    res_next.found    = hit_reg;
                    res_next.position = hit_reg ? POS_W'(smaller_reg + CNT_W'(1)) : '0;
                    res_next.rejected = 1'b0;
                    res_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_pending_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_pending_reg <= rd_pending_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        smaller_reg <= smaller_next;
        hit_reg     <= hit_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
    end

    assign res_data         = res_reg;
    assign status.res_valid = res_valid_reg;
    assign status.count     = count_reg;

endmodule

// ===== rtl/sorted_rank_lookup.sv =====
// Holds a set of up to CAPACITY (1024) signed 32-bit values in a single-port
// memory. One item is worked on at a time. A clear, an append or a query on an
// empty set puts its result in the engine's result register and from there in
// the output register that drives out_valid; the next item can be transferred
// once that result has left the engine. A query scans every stored entry once
// through the one memory port, and the next item can follow once its result
// has left the engine. A result held in the output register lets one more
// item in; a second finished result waits in the engine and holds off the
// input until the output moves on.
// The store needs no clearing pass after reset: only entries below the count
// are ever read.
// top level: srl_engine, srl_mem and the output register; depends on srl_pkg
module sorted_rank_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  srl_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output srl_pkg::out_item_t out_data
);
    import srl_pkg::*;

    mem_req_t    mem_req;
    logic [31:0] mem_rdata;
    out_item_t   res_data;
    eng_status_t status;
    logic        res_take;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg;

    srl_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    srl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_take  (res_take),
        .res_data  (res_data),
        .status    (status)
    );

    // output slot frees up when empty or being transferred this cycle
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = status.res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && status.res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= CNT_W'(CAPACITY))
        else $error("stored count beyond capacity");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !status.res_valid)
        else $error("transfer in while a result is pending");

    a_found_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.found && out_data.rejected))
        else $error("result both found and rejected");

    a_absent_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.position == '0))
        else $error("position given for an absent value");

endmodule

// ===== tb/sorted_rank_lookup_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for sorted_rank_lookup: directed and random clear, append and query
// transfers, results predicted by a scoreboard class; depends on srl_pkg and the block's rtl
module sorted_rank_lookup_tb;

    import srl_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int QUIET_LIMIT = 8000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int RANDOM_ITEMS = 580;

    class rank_scoreboard;
        logic signed [31:0] held [CAPACITY];
        int unsigned        held_count;
        out_item_t          expected_q [$];
        int unsigned        errors;

        function new();
            held_count = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // rank of the first equal element = count of strictly smaller values plus one
        function void note_input(in_item_t item);
            out_item_t          r;
            logic signed [31:0] probe;
            int unsigned        below;
            bit                 hit;
            r = '0;
            probe = item.value;
            below = 0;
            hit = 1'b0;
            case (item.opcode)
                OP_CLEAR: held_count = 0;
                OP_APPEND:
                begin
                    if (held_count >= CAPACITY)
                        r.rejected = 1'b1;
                    else
                    begin
                        held[held_count] = probe;
                        held_count++;
                    end
                end
                OP_QUERY:
                begin
                    for (int k = 0; k < held_count; k++)
                    begin
                        if (held[k] == probe)
                            hit = 1'b1;
                        else if (held[k] < probe)
                            below++;
                    end
                    if (hit)
                    begin
                        r.found = 1'b1;
                        r.position = POS_W'(below + 1);
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("found", want.found, got.found);
                compare_field("position", want.position, got.position);
                compare_field("rejected", want.rejected, got.rejected);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    rank_scoreboard board;
    bit             calm = 1'b0;
    int unsigned    gap_pct = 0;
    int unsigned    stall_pct = 0;
    int unsigned    stall_left = 0;
    int unsigned    sent = 0;
    int unsigned    quiet_cycles = 0;

    sorted_rank_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure in bursts
    always @(posedge clk)
    begin
        if (calm)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_left <= $urandom_range(15, 1);
            out_stall <= 1'b1;
        end
    end

    // handshake signals only move at the rising edge, so the falling edge sees them settled
    always @(negedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_input(in_data);
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return $signed(32'($urandom_range(16))) - 32'sd8;
        else if (r < 50)
            return ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
        else
            return $urandom;
    endfunction

    // valid stays high between back-to-back transfers; it only drops for a gap or while draining
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] v);
        bit took;
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
        in_data <= '{opcode: op, value: v};
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        if (op != OP_SPARE)
            sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // one set: optional clear, appends, then queries mixed with some noise
    task automatic run_batch();
        logic signed [31:0] kept [$];
        logic signed [31:0] v;
        int unsigned        n_app;
        int unsigned        n_qry;
        int unsigned        r;
        case ($urandom_range(3))
            0: gap_pct = 0;
            1: gap_pct = 10;
            2: gap_pct = 35;
            default: gap_pct = 70;
        endcase
        stall_pct <= ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
        if ($urandom_range(99) < 85)
            send_item(OP_CLEAR, pick_value());
        if ($urandom_range(3) == 0)
            n_app = $urandom_range(60, 13);
        else
            n_app = $urandom_range(12);
        repeat (n_app)
        begin
            v = pick_value();
            kept.push_back(v);
            send_item(OP_APPEND, v);
        end
        n_qry = $urandom_range(8, 1);
        repeat (n_qry)
        begin
            r = $urandom_range(99);
            if (r < 5)
                send_item(OP_SPARE, $urandom);
            else if (r < 12)
                send_item(OP_APPEND, pick_value());
            else if (r < 60 && kept.size() != 0)
                send_item(OP_QUERY, kept[$urandom_range(kept.size() - 1)]);
            else
                send_item(OP_QUERY, pick_value());
        end
        if ($urandom_range(5) == 0)
            wait_drain();
    endtask

    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 25;
        stall_pct <= 25;
        send_item(OP_QUERY, 32'sd0);
        send_item(OP_SPARE, 32'shffff_ffff);
        send_item(OP_APPEND, VAL_MIN);
        send_item(OP_APPEND, VAL_MAX);
        send_item(OP_APPEND, 32'sd0);
        send_item(OP_APPEND, -32'sd1);
        send_item(OP_APPEND, 32'sd5);
        send_item(OP_APPEND, 32'sd5);
        send_item(OP_APPEND, -32'sd7);
        send_item(OP_QUERY, VAL_MIN);
        send_item(OP_QUERY, VAL_MAX);
        send_item(OP_QUERY, 32'sd5);
        send_item(OP_QUERY, -32'sd1);
        send_item(OP_QUERY, 32'sd0);
        send_item(OP_QUERY, -32'sd7);
        send_item(OP_QUERY, 32'sd123);
        send_item(OP_SPARE, 32'sd7);
        send_item(OP_QUERY, -32'sd1);
        send_item(OP_CLEAR, 32'sd0);
        send_item(OP_QUERY, 32'sd5);
        send_item(OP_APPEND, 32'sd1);
        send_item(OP_QUERY, 32'sd1);
        send_item(OP_APPEND, 32'sd1);
        send_item(OP_QUERY, 32'sd1);
        wait_drain();

        while (sent < RANDOM_ITEMS)
        begin
            run_batch();
            if (sent >= RANDOM_ITEMS - 100)
                calm <= 1'b1;
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
